// ===== hdl/dvl_pkg.sv =====
// Shared constants, types and lane arithmetic for the directional vertex lighting block.
package dvl_pkg;

  localparam int unsigned LaneW     = 16;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned RegW      = LaneW * NumLanes;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ProdW     = 2 * LaneW;
  localparam int unsigned DotShift  = 15;
  localparam int unsigned OutShift  = 4;
  localparam int unsigned CfgIdxW   = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegNormalBias    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLightDir      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAmbient       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLitColor      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIncidentColor = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShadeColor    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBackColor     = 3'd6;

  // Result of the dot stages handed to the color stages
  typedef struct packed {
    logic                    valid;
    logic                    eob;
    logic signed [LaneW-1:0] f;
    logic signed [LaneW-1:0] nf;
  } dot_out_t;

  // Signed 16-bit lane i of a packed 64-bit register
  function automatic logic signed [LaneW-1:0] lane(input logic [RegW-1:0] w, input int i);
    lane = w[LaneW*i +: LaneW];
  endfunction

  // Upper half of the signed 16x16 product
  function automatic logic signed [LaneW-1:0] mulhi(input logic signed [LaneW-1:0] a,
                                                    input logic signed [LaneW-1:0] b);
    logic signed [ProdW-1:0] p;
    p = ProdW'(a) * ProdW'(b);
    mulhi = p[ProdW-1:LaneW];
  endfunction

  // Arithmetic shift by four, clamped to an unsigned byte
  function automatic logic [ByteW-1:0] sat_byte(input logic [LaneW-1:0] v);
    if (v[LaneW-1]) begin
      sat_byte = '0;
    end else if (|v[LaneW-2:OutShift+ByteW]) begin
      sat_byte = '1;
    end else begin
      sat_byte = v[OutShift+ByteW-1:OutShift];
    end
  endfunction

endpackage

// ===== hdl/dvl_dot_unit.sv =====
// Normal expansion, biased dot product with the light direction, and the f / nf factors.
module dvl_dot_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 normal_word_i,
  input  logic                        end_of_batch_i,
  input  logic [dvl_pkg::RegW-1:0]    normal_bias_i,
  input  logic [dvl_pkg::RegW-1:0]    light_direction_i,
  input  logic                        take_i,
  output dvl_pkg::dot_out_t           dot_o
);

  localparam int unsigned ProdW = dvl_pkg::ProdW;

  logic                                  v1_q, v2_q;
  logic                                  eob1_q, eob2_q;
  logic                                  en1, en2;
  logic signed [dvl_pkg::ProdW-1:0]      prod_d [dvl_pkg::NumLanes];
  logic signed [dvl_pkg::ProdW-1:0]      prod_q [dvl_pkg::NumLanes];
  logic signed [dvl_pkg::LaneW-1:0]      f_d, nf_d, f_q, nf_q;
  logic [dvl_pkg::ProdW-1:0]             sum;
  logic [dvl_pkg::LaneW-1:0]             dbits;

  // Stage advance: a stage moves when empty or when the next one moves
  assign en2        = !v2_q || take_i;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // Stage 1: expand bytes (b*257), subtract bias, multiply by direction
  always_comb begin
    logic [dvl_pkg::LaneW-1:0] n;
    logic [dvl_pkg::ByteW-1:0] b;
    for (int i = 0; i < dvl_pkg::NumLanes; i++) begin
      b         = normal_word_i[dvl_pkg::ByteW*i +: dvl_pkg::ByteW];
      n         = {b, b} - normal_bias_i[dvl_pkg::LaneW*i +: dvl_pkg::LaneW];
      prod_d[i] = ProdW'($signed(n)) * ProdW'(dvl_pkg::lane(light_direction_i, i));
    end
  end

  // Stage 2: pairwise sum, take bits 30..15 as d, derive f and nf
  always_comb begin
    sum   = (prod_q[0] + prod_q[1]) + (prod_q[2] + prod_q[3]);
    dbits = sum[dvl_pkg::DotShift +: dvl_pkg::LaneW];
    f_d   = dbits[dvl_pkg::LaneW-1] ? '0 : $signed(dbits);
    // non-negative dot leaves nf at all ones
    nf_d  = dbits[dvl_pkg::LaneW-1] ? $signed(~dbits) : '1;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
      eob1_q <= end_of_batch_i;
    end
    if (en2) begin
      f_q    <= f_d;
      nf_q   <= nf_d;
      eob2_q <= eob1_q;
    end
  end

  assign dot_o.valid = v2_q;
  assign dot_o.eob   = eob2_q;
  assign dot_o.f     = f_q;
  assign dot_o.nf    = nf_q;

endmodule

// ===== hdl/directional_vertex_lighting.sv =====
// Top level of the directional vertex lighting pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: a packed normal
//   word and an end-of-batch flag. Output channel (out_valid_o / out_stall_i)
//   returns one item per input: packed main color, packed shadow color and the
//   copied batch flag. Items transfer when valid is high and stall is low.
//   The config port writes one of seven 64-bit lane registers per cycle when
//   cfg_we_i is high; index 7 is ignored. Write only while the pipe is empty.
// Stages: expand/multiply, dot sum, color multiplies, sum and saturate, each a
//   register stage, from input accept to output valid.
// Throughput: one item per cycle unless the output stalls; each stage has a
//   valid bit and moves when empty or when the next moves; bubbles close up.
// Reset: asynchronous, active low; clears all valid bits and the config
//   registers to 0. Data registers are not reset.
// Stall: a stalled output holds its item; the pipe keeps filling until every
//   stage is full, then in_stall_o rises. No item is lost or repeated.
module directional_vertex_lighting (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    normal_word_i,
  input  logic                           end_of_batch_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    lit_rgba_o,
  output logic [31:0]                    shadowed_rgba_o,
  output logic                           batch_done_o,
  input  logic                           cfg_we_i,
  input  logic [dvl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dvl_pkg::RegW-1:0]       cfg_wdata_i
);

  localparam int unsigned LaneW = dvl_pkg::LaneW;
  localparam int unsigned ByteW = dvl_pkg::ByteW;

  logic [dvl_pkg::RegW-1:0] bias_q, dir_q, amb_q, lit_q, inc_q, shade_q, back_q;

  dvl_pkg::dot_out_t            dot;
  logic                         en3, en4;
  logic                         v3_q, v4_q, eob3_q, eob4_q;
  logic signed [LaneW-1:0]      mh_lit_d [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_back_d [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_inc_d [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_shade_d [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_lit_q [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_back_q [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_inc_q [dvl_pkg::NumLanes];
  logic signed [LaneW-1:0]      mh_shade_q [dvl_pkg::NumLanes];
  logic [31:0]                  lit_rgba_d, shd_rgba_d, lit_rgba_q, shd_rgba_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q  <= '0;
      dir_q   <= '0;
      amb_q   <= '0;
      lit_q   <= '0;
      inc_q   <= '0;
      shade_q <= '0;
      back_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dvl_pkg::RegNormalBias:    bias_q  <= cfg_wdata_i;
        dvl_pkg::RegLightDir:      dir_q   <= cfg_wdata_i;
        dvl_pkg::RegAmbient:       amb_q   <= cfg_wdata_i;
        dvl_pkg::RegLitColor:      lit_q   <= cfg_wdata_i;
        dvl_pkg::RegIncidentColor: inc_q   <= cfg_wdata_i;
        dvl_pkg::RegShadeColor:    shade_q <= cfg_wdata_i;
        dvl_pkg::RegBackColor:     back_q  <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Stage advance for the color half
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;

  // Stages 1 and 2
  dvl_dot_unit u_dot (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .normal_word_i     (normal_word_i),
    .end_of_batch_i    (end_of_batch_i),
    .normal_bias_i     (bias_q),
    .light_direction_i (dir_q),
    .take_i            (en3),
    .dot_o             (dot)
  );

  // Stage 3: upper halves of the sixteen lane products (four colors, four lanes)
  always_comb begin
    for (int i = 0; i < dvl_pkg::NumLanes; i++) begin
      mh_lit_d[i]   = dvl_pkg::mulhi(dvl_pkg::lane(lit_q, i), dot.f);
      mh_inc_d[i]   = dvl_pkg::mulhi(dvl_pkg::lane(inc_q, i), dot.f);
      mh_back_d[i]  = dvl_pkg::mulhi(dvl_pkg::lane(back_q, i), dot.nf);
      mh_shade_d[i] = dvl_pkg::mulhi(dvl_pkg::lane(shade_q, i), dot.nf);
    end
  end

  // Stage 4: ambient plus both terms, wrap at 16 bits, shift and clamp
  always_comb begin
    logic [LaneW-1:0] c, s, amb;
    for (int i = 0; i < dvl_pkg::NumLanes; i++) begin
      amb = amb_q[LaneW*i +: LaneW];
      c   = amb + mh_lit_q[i] + mh_back_q[i];
      s   = amb + mh_inc_q[i] + mh_shade_q[i];
      lit_rgba_d[ByteW*i +: ByteW] = dvl_pkg::sat_byte(c);
      shd_rgba_d[ByteW*i +: ByteW] = dvl_pkg::sat_byte(s);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= dot.valid;
      if (en4) v4_q <= v3_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en3) begin
      mh_lit_q   <= mh_lit_d;
      mh_back_q  <= mh_back_d;
      mh_inc_q   <= mh_inc_d;
      mh_shade_q <= mh_shade_d;
      eob3_q     <= dot.eob;
    end
    if (en4) begin
      lit_rgba_q <= lit_rgba_d;
      shd_rgba_q <= shd_rgba_d;
      eob4_q     <= eob3_q;
    end
  end

  assign out_valid_o     = v4_q;
  assign lit_rgba_o      = lit_rgba_q;
  assign shadowed_rgba_o = shd_rgba_q;
  assign batch_done_o    = eob4_q;

endmodule

// ===== hdl/dvl_checker.sv =====
// Port-level checks for the directional vertex lighting pipeline, bound to the top level.
module dvl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        end_of_batch_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [31:0]                 lit_rgba_o,
  input logic [31:0]                 shadowed_rgba_o,
  input logic                        batch_done_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled output item stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A stalled output item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(lit_rgba_o) && $stable(shadowed_rgba_o)
                                   && $stable(batch_done_o))
    else $error("output payload changed while stalled");

  // Input stalls only when the pipe is full behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // With no output stall, an accepted item reaches the output with its batch flag
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o && (batch_done_o == $past(end_of_batch_i, 4)))
    else $error("item did not arrive after four cycles");

endmodule

bind directional_vertex_lighting dvl_checker u_dvl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .end_of_batch_i  (end_of_batch_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .lit_rgba_o      (lit_rgba_o),
  .shadowed_rgba_o (shadowed_rgba_o),
  .batch_done_o    (batch_done_o)
);
